### hw/rtl/sm4_pkg.sv
// Shared types, constants and round functions for the SM4 block encryptor.
package sm4_pkg;

    localparam int ROUNDS     = 32;
    localparam int RND_W      = $clog2(ROUNDS);
    localparam int WORD_W     = 32;
    localparam int HALF_W     = 64;
    localparam int CFG_IDX_W  = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = CFG_IDX_W'(1);

    localparam logic [RND_W-1:0] LAST_ROUND = RND_W'(ROUNDS - 1);

    // Family key constants
    localparam logic [WORD_W-1:0] FK0 = 32'ha3b1bac6;
    localparam logic [WORD_W-1:0] FK1 = 32'h56aa3350;
    localparam logic [WORD_W-1:0] FK2 = 32'h677d9197;
    localparam logic [WORD_W-1:0] FK3 = 32'hb27022dc;

    localparam logic [7:0] SBOX [256] = '{
        8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
        8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
        8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
        8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
        8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
        8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
        8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
        8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
        8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
        8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
        8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
        8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
        8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
        8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
        8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
        8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
    };

    // Controller states, one-hot
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_KEY  = 4'b0010,
        ST_ENC  = 4'b0100,
        ST_DONE = 4'b1000
    } sm4_state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic             load;
        logic             key_step;
        logic             enc_step;
        logic [RND_W-1:0] round;
    } sm4_cmd_t;

    function automatic logic [WORD_W-1:0] sub_word(input logic [WORD_W-1:0] v);
        return {SBOX[v[31:24]], SBOX[v[23:16]], SBOX[v[15:8]], SBOX[v[7:0]]};
    endfunction

    function automatic logic [WORD_W-1:0] rol(input logic [WORD_W-1:0] v, input int n);
        return (v << n) | (v >> (WORD_W - n));
    endfunction

    // CK word: byte j of word i is (4*i + j) * 7 mod 256
    function automatic logic [WORD_W-1:0] ck_word(input logic [RND_W-1:0] i);
        logic [WORD_W-1:0] w;
        w = '0;
        for (int j = 0; j < 4; j++)
        begin
            w = {w[WORD_W-9:0], 8'({1'b0, i, 2'(j)} * 8'd7)};
        end
        return w;
    endfunction

endpackage

### hw/rtl/sm4_block_encrypt.sv
// SM4 block encryptor top level: controller plus datapath.
// The result strobe follows the encryption rounds, which start at the accepting edge,
// or after the 32-round key schedule when it runs first (after reset or a key write).
// A new block is accepted only while idle, as one cipher round unit serves every round.
// Reset clears the key registers, the controller and the key-ready flag;
// the round key RAM is not cleared. Results cannot be stalled by the receiver.
module sm4_block_encrypt
    import sm4_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [HALF_W-1:0]    block_high,
    input  logic [HALF_W-1:0]    block_low,
    output logic                 done,
    output logic [HALF_W-1:0]    cipher_high,
    output logic [HALF_W-1:0]    cipher_low,
    input  logic                 write_en,
    input  logic [CFG_IDX_W-1:0] write_index,
    input  logic [HALF_W-1:0]    write_data
);

    sm4_cmd_t cmd;

    sm4_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .write_en    (write_en),
        .write_index (write_index),
        .busy        (busy),
        .done        (done),
        .cmd         (cmd)
    );

    sm4_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .write_en    (write_en),
        .write_index (write_index),
        .write_data  (write_data),
        .block_high  (block_high),
        .block_low   (block_low),
        .cipher_high (cipher_high),
        .cipher_low  (cipher_low)
    );

endmodule

### hw/rtl/sm4_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sm4_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### hw/rtl/sm4_ctrl.sv
// Controller state machine: sequences key schedule and encryption rounds.
module sm4_ctrl
    import sm4_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 write_en,
    input  logic [CFG_IDX_W-1:0] write_index,
    output logic                 busy,
    output logic                 done,
    output sm4_cmd_t             cmd
);

    sm4_state_t       state_reg, state_next;
    logic [RND_W-1:0] cnt_reg, cnt_next;
    logic             keys_ready_reg, keys_ready_next;
    logic             key_write;
    logic             accept;

    assign key_write = write_en && (write_index == REG_KEY_HIGH || write_index == REG_KEY_LOW);
    assign busy      = (state_reg != ST_IDLE);
    assign done      = (state_reg == ST_DONE);
    assign accept    = start && !busy;

    // Next state, round counter and key-ready flag
    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        keys_ready_next = keys_ready_reg;
        case (state_reg)
            ST_IDLE:
            begin
                cnt_next = '0;
                if (start)
                begin
                    state_next = keys_ready_reg ? ST_ENC : ST_KEY;
                end
            end
            ST_KEY:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_ROUND)
                begin
                    state_next      = ST_ENC;
                    keys_ready_next = 1'b1;
                end
            end
            ST_ENC:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_ROUND)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        // Drop the round keys on any key write
        if (key_write)
        begin
            keys_ready_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            keys_ready_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            keys_ready_reg <= keys_ready_next;
        end
    end

    // Drive datapath commands
    always_comb
    begin
        cmd.load     = accept;
        cmd.key_step = (state_reg == ST_KEY);
        cmd.enc_step = (state_reg == ST_ENC);
        cmd.round    = cnt_reg;
    end

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("accepted request did not raise busy");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> (state_reg == ST_IDLE))
        else $error("result strobe lasted more than one cycle");

    a_key_clear: assert property (@(posedge clk) disable iff (!rst_n)
        key_write |=> !keys_ready_reg)
        else $error("key write did not invalidate round keys");

    a_sched_to_enc: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_KEY && cnt_reg == LAST_ROUND) |=> (state_reg == ST_ENC))
        else $error("key schedule did not hand over to encryption");

endmodule

### hw/rtl/sm4_dp.sv
// Datapath: key registers, key schedule round, cipher round and round key RAM.
module sm4_dp
    import sm4_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  sm4_cmd_t             cmd,
    input  logic                 write_en,
    input  logic [CFG_IDX_W-1:0] write_index,
    input  logic [HALF_W-1:0]    write_data,
    input  logic [HALF_W-1:0]    block_high,
    input  logic [HALF_W-1:0]    block_low,
    output logic [HALF_W-1:0]    cipher_high,
    output logic [HALF_W-1:0]    cipher_low
);

    logic [HALF_W-1:0] key_high_reg, key_low_reg;
    logic [WORD_W-1:0] k_reg [4];
    logic [WORD_W-1:0] x_reg [4];
    logic [WORD_W-1:0] key_t, key_nk;
    logic [WORD_W-1:0] enc_b, enc_nx;
    logic [WORD_W-1:0] rk_rdata;
    logic [RND_W-1:0]  rk_raddr;

    // Hold the cipher key
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
        end
        else if (write_en)
        begin
            if (write_index == REG_KEY_HIGH)
            begin
                key_high_reg <= write_data;
            end
            else if (write_index == REG_KEY_LOW)
            begin
                key_low_reg <= write_data;
            end
        end
    end

    // One key schedule round
    assign key_t  = sub_word(k_reg[1] ^ k_reg[2] ^ k_reg[3] ^ ck_word(cmd.round));
    assign key_nk = k_reg[0] ^ key_t ^ rol(key_t, 13) ^ rol(key_t, 23);

    // One cipher round
    assign enc_b  = sub_word(x_reg[1] ^ x_reg[2] ^ x_reg[3] ^ rk_rdata);
    assign enc_nx = x_reg[0] ^ enc_b ^ rol(enc_b, 2) ^ rol(enc_b, 10)
                    ^ rol(enc_b, 18) ^ rol(enc_b, 24);

    // Load on request, then shift one word per round
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            k_reg[0] <= key_high_reg[63:32] ^ FK0;
            k_reg[1] <= key_high_reg[31:0]  ^ FK1;
            k_reg[2] <= key_low_reg[63:32]  ^ FK2;
            k_reg[3] <= key_low_reg[31:0]   ^ FK3;
            x_reg[0] <= block_high[63:32];
            x_reg[1] <= block_high[31:0];
            x_reg[2] <= block_low[63:32];
            x_reg[3] <= block_low[31:0];
        end
        else
        begin
            if (cmd.key_step)
            begin
                k_reg[0] <= k_reg[1];
                k_reg[1] <= k_reg[2];
                k_reg[2] <= k_reg[3];
                k_reg[3] <= key_nk;
            end
            if (cmd.enc_step)
            begin
                x_reg[0] <= x_reg[1];
                x_reg[1] <= x_reg[2];
                x_reg[2] <= x_reg[3];
                x_reg[3] <= enc_nx;
            end
        end
    end

    // Prefetch the next round key; round 0 is read while idle or scheduling
    assign rk_raddr = cmd.enc_step ? (cmd.round + 1'b1) : '0;

    sm4_ram #(
        .WIDTH (WORD_W),
        .DEPTH (ROUNDS)
    ) u_rk_ram (
        .clk   (clk),
        .we    (cmd.key_step),
        .waddr (cmd.round),
        .wdata (key_nk),
        .raddr (rk_raddr),
        .rdata (rk_rdata)
    );

    // Reverse word order for the result
    assign cipher_high = {x_reg[3], x_reg[2]};
    assign cipher_low  = {x_reg[1], x_reg[0]};

endmodule
